@@ src/olst_pkg.sv @@
// ----------------------------------------------------------------------------
// olst_pkg: shared types and constants for the ordered list store
// Operation and status codes, cell control word and stream widths.
// ----------------------------------------------------------------------------
package olst_pkg;

    // default sizing
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // stream payload widths
    localparam int OP_W       = 3;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int FIDX_W     = 4;
    localparam int ICOUNT_W   = 5;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT_AT  = 3'd4,
        OP_SEARCH     = 3'd5
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BOUNDS = 2'd3
    } status_t;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic open_slot;   // cells at and above the slot move up one place
        logic shift_down;  // every cell takes its upper neighbor
    } cell_ctl_t;

endpackage

@@ src/ordered_list_store.sv @@
// ----------------------------------------------------------------------------
// ordered_list_store: bounded ordered list of signed values
// Row of entry cells with a small sequencer for push, pop, insert and search.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the s_axis channel is one operation (push front, push
//   back, pop front, pop back, insert at a position, search for a key). Each
//   operation gives exactly one transfer on the m_axis channel carrying the
//   status, the search result and the entry count after the operation.
//   Push, insert and pop front shift the cells, pop back only drops the count:
//   the result is in the output register the cycle after the transfer, and a
//   new operation is taken every cycle while the receiver keeps up.
//   Search scans the per-cell match flags from the front, one cell a cycle,
//   stopping at the first match or the last entry, and no other operation is
//   taken meanwhile. A search on an empty list finishes at once.
//   When the receiver stalls, the result waits in the output register and
//   s_axis_tready stays low until it is taken or taken in the same cycle.
//   Reset empties the list (count zero); entry contents are not cleared,
//   only entries below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_store #(
    parameter int DEPTH      = olst_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = olst_pkg::DATA_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // op [2:0], value [34:3], position [39:35]
    input  logic [olst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status [1:0], found [2], found_index [6:3], item_count [11:7], zeros above
    output logic [olst_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > olst_pkg::POS_W) ? CNT_W : olst_pkg::POS_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;

    logic out_valid_reg, out_valid_next;
    olst_pkg::status_t status_reg, status_next;
    logic found_reg, found_next;
    logic [olst_pkg::FIDX_W-1:0] fidx_reg, fidx_next;
    logic [olst_pkg::ICOUNT_W-1:0] icount_reg, icount_next;

    // input fields
    logic [olst_pkg::OP_W-1:0]    in_op;
    logic [olst_pkg::VALUE_W-1:0] in_value;
    logic [olst_pkg::POS_W-1:0]   in_pos;
    logic [DATA_WIDTH-1:0]        value_ext;
    logic [CMP_W-1:0]             pos_ext;
    logic [CMP_W-1:0]             cnt_ext;
    logic [CMP_W-1:0]             scan_ext;
    logic [CMP_W-1:0]             cnt_next_ext;

    logic accept;
    logic out_free;
    logic full;
    logic empty;
    logic hit;

    olst_pkg::cell_ctl_t  ctl;
    logic [ADDR_W-1:0]    at;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]     match_vec;

    assign in_op    = s_axis_tdata[2:0];
    assign in_value = s_axis_tdata[34:3];
    assign in_pos   = s_axis_tdata[39:35];

    // sign-extend or truncate the value to the entry width
    always_comb
    begin
        for (int b = 0; b < DATA_WIDTH; b++)
        begin
            value_ext[b] = in_value[(b < olst_pkg::VALUE_W) ? b : olst_pkg::VALUE_W - 1];
        end
    end

    assign pos_ext  = CMP_W'(in_pos);
    assign cnt_ext  = CMP_W'(count_reg);
    assign scan_ext = CMP_W'(scan_reg);
    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign hit           = match_vec[scan_reg[ADDR_W-1:0]];

    // row of entry cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end

        olst_cell #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .at         (at),
            .din        (value_ext),
            .left_data  (left_d),
            .right_data (right_d),
            .key        (key_reg),
            .data       (cell_data[i]),
            .match      (match_vec[i])
        );
    end

    // operation decode and sequencing
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        status_next    = status_reg;
        found_next     = found_reg;
        fidx_next      = fidx_reg;
        icount_next    = icount_reg;
        cnt_next_ext   = '0;
        ctl            = '0;
        at             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    status_next    = olst_pkg::ST_OK;
                    found_next     = 1'b0;
                    fidx_next      = '0;
                    case (in_op)
                        olst_pkg::OP_PUSH_FRONT,
                        olst_pkg::OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = olst_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.open_slot = 1'b1;
                                at = (in_op == olst_pkg::OP_PUSH_FRONT) ? '0
                                                                        : count_reg[ADDR_W-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        olst_pkg::OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = olst_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctl.shift_down = 1'b1;
                                count_next     = count_reg - 1'b1;
                            end
                        end
                        olst_pkg::OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = olst_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        olst_pkg::OP_INSERT_AT:
                        begin
                            if (pos_ext > cnt_ext)
                            begin
                                status_next = olst_pkg::ST_BOUNDS;
                            end
                            else if (full)
                            begin
                                status_next = olst_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.open_slot = 1'b1;
                                at            = pos_ext[ADDR_W-1:0];
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        olst_pkg::OP_SEARCH:
                        begin
                            if (!empty)
                            begin
                                // hold the result back until the scan ends
                                out_valid_next = 1'b0;
                                key_next       = value_ext;
                                scan_next      = '0;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    cnt_next_ext = CMP_W'(count_next);
                    icount_next  = cnt_next_ext[olst_pkg::ICOUNT_W-1:0];
                end
            end
            S_SCAN:
            begin
                // output register is empty here: it was free when the search came in
                if (hit)
                begin
                    out_valid_next = 1'b1;
                    status_next    = olst_pkg::ST_OK;
                    found_next     = 1'b1;
                    fidx_next      = scan_ext[olst_pkg::FIDX_W-1:0];
                    icount_next    = cnt_ext[olst_pkg::ICOUNT_W-1:0];
                    state_next     = S_IDLE;
                end
                else if (scan_reg + 1'b1 == count_reg)
                begin
                    out_valid_next = 1'b1;
                    status_next    = olst_pkg::ST_OK;
                    found_next     = 1'b0;
                    fidx_next      = '0;
                    icount_next    = cnt_ext[olst_pkg::ICOUNT_W-1:0];
                    state_next     = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        fidx_reg   <= fidx_next;
        icount_reg <= icount_next;
    end

    // result transfer
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, icount_reg, fidx_reg, found_reg, status_reg};

    // count never exceeds the number of cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    // no result is pending while a search scan runs
    a_scan_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !out_valid_reg)
        else $error("result pending during scan");

    // a full status leaves the list full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == olst_pkg::ST_FULL) |-> full)
        else $error("full status with room left");

    // a search hit is reported as a found result with ok status
    a_found_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && hit) |=> (found_reg && status_reg == olst_pkg::ST_OK
                                          && out_valid_reg))
        else $error("search hit not reported");

endmodule

@@ src/olst_cell.sv @@
// ----------------------------------------------------------------------------
// olst_cell: one entry of the ordered list store
// Holds one value, takes a neighbor's value on push, insert or pop front, and compares
// its value against the search key.
// ----------------------------------------------------------------------------
module olst_cell #(
    parameter int DEPTH      = olst_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = olst_pkg::DATA_WIDTH_DEF,
    parameter int IDX        = 0
) (
    input  logic                   clk,
    input  olst_pkg::cell_ctl_t    ctl,
    input  logic [$clog2(DEPTH)-1:0] at,
    input  logic [DATA_WIDTH-1:0]  din,
    input  logic [DATA_WIDTH-1:0]  left_data,
    input  logic [DATA_WIDTH-1:0]  right_data,
    input  logic [DATA_WIDTH-1:0]  key,
    output logic [DATA_WIDTH-1:0]  data,
    output logic                   match
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] MY_IDX = ADDR_W'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // select the new entry value
    always_comb
    begin
        data_next = data_reg;
        if (ctl.open_slot)
        begin
            if (MY_IDX > at)
            begin
                data_next = left_data;
            end
            else if (MY_IDX == at)
            begin
                data_next = din;
            end
        end
        else if (ctl.shift_down)
        begin
            data_next = right_data;
        end
    end

    // entry storage, contents undefined until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == key);

endmodule

@@ dv/tb_ordered_list_store.sv @@
// ----------------------------------------------------------------------------
// tb_ordered_list_store: self-checking testbench for the ordered list store
// Drives list operations over the input stream with random gaps, predicts
// every result with a software copy of the list and checks each output
// transfer field by field, with long output stalls and full drains on the way.
// ----------------------------------------------------------------------------
module tb_ordered_list_store;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = olst_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;

    // op codes the block treats as no operation
    localparam logic [olst_pkg::OP_W-1:0] OP_NOP_6 = 3'd6;
    localparam logic [olst_pkg::OP_W-1:0] OP_NOP_7 = 3'd7;

    // one result word, zero padding at the top, then item_count, status at the bottom
    typedef struct packed {
        logic [3:0]                    pad;
        logic [olst_pkg::ICOUNT_W-1:0] cnt;
        logic [olst_pkg::FIDX_W-1:0]   fidx;
        logic                          found;
        olst_pkg::status_t             status;
    } list_result_t;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

    // ------------------------------------------------------------------------
    // list shadow: keeps its own copy of the list and the queue of results
    // ------------------------------------------------------------------------
    class list_scoreboard;
        logic [olst_pkg::VALUE_W-1:0] slots[LIST_DEPTH];
        int unsigned        held;
        list_result_t       owed[$];
        int                 errors;
        int                 n_ops;
        int                 n_checked;
        int                 n_full;
        int                 n_empty;
        int                 n_bounds;
        int                 n_found;
        int                 peak;

        function new();
            held = 0;
            errors = 0;
            n_ops = 0;
            n_checked = 0;
            n_full = 0;
            n_empty = 0;
            n_bounds = 0;
            n_found = 0;
            peak = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // open a slot at index at, moving the tail up one place
        function void open_at(int unsigned at, logic [olst_pkg::VALUE_W-1:0] val);
            int unsigned i;
            for (i = held; i > at; i--)
                slots[i] = slots[i-1];
            slots[at] = val;
            held++;
        endfunction

        // apply one accepted operation and queue the result it owes
        function void note_op(logic [olst_pkg::OP_W-1:0] op_code,
                              logic [olst_pkg::VALUE_W-1:0] val,
                              logic [olst_pkg::POS_W-1:0] pos);
            list_result_t r;
            int unsigned  i;
            r = '0;
            r.status = olst_pkg::ST_OK;
            case (op_code)
                olst_pkg::OP_PUSH_FRONT, olst_pkg::OP_PUSH_BACK:
                begin
                    if (held >= LIST_DEPTH)
                        r.status = olst_pkg::ST_FULL;
                    else
                        open_at((op_code == olst_pkg::OP_PUSH_FRONT) ? 0 : held, val);
                end
                olst_pkg::OP_POP_FRONT:
                begin
                    if (held == 0)
                        r.status = olst_pkg::ST_EMPTY;
                    else
                    begin
                        for (i = 0; i + 1 < held; i++)
                            slots[i] = slots[i+1];
                        held--;
                    end
                end
                olst_pkg::OP_POP_BACK:
                begin
                    if (held == 0)
                        r.status = olst_pkg::ST_EMPTY;
                    else
                        held--;
                end
                olst_pkg::OP_INSERT_AT:
                begin
                    // bounds check wins over the full check
                    if (pos > held)
                        r.status = olst_pkg::ST_BOUNDS;
                    else if (held >= LIST_DEPTH)
                        r.status = olst_pkg::ST_FULL;
                    else
                        open_at(pos, val);
                end
                olst_pkg::OP_SEARCH:
                begin
                    for (i = 0; i < held; i++)
                    begin
                        if (slots[i] == val)
                        begin
                            r.found = 1'b1;
                            r.fidx  = i[olst_pkg::FIDX_W-1:0];
                            break;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            r.cnt = held[olst_pkg::ICOUNT_W-1:0];
            if (r.status == olst_pkg::ST_FULL)   n_full++;
            if (r.status == olst_pkg::ST_EMPTY)  n_empty++;
            if (r.status == olst_pkg::ST_BOUNDS) n_bounds++;
            if (r.found)                         n_found++;
            if (held > peak)                     peak = held;
            n_ops++;
            owed.push_back(r);
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= REPORT_MAX)
                $display("mismatch at %0t: %s", $time, what);
        endfunction

        // compare one output transfer against the oldest owed result
        function void check_result(logic [olst_pkg::OUT_DATA_W-1:0] word);
            list_result_t want;
            list_result_t got;
            got = list_result_t'(word);
            if (owed.size() == 0)
            begin
                flag($sformatf("unexpected result 0x%04h", word));
                return;
            end
            want = owed.pop_front();
            n_checked++;
            if (got.status !== want.status)
                flag($sformatf("status exp %0d got %0d", want.status, got.status));
            if (got.found !== want.found)
                flag($sformatf("found exp %0d got %0d", want.found, got.found));
            if (got.fidx !== want.fidx)
                flag($sformatf("found_index exp %0d got %0d", want.fidx, got.fidx));
            if (got.cnt !== want.cnt)
                flag($sformatf("item_count exp %0d got %0d", want.cnt, got.cnt));
            if (got.pad !== want.pad)
                flag($sformatf("upper bits exp 0 got 0x%0h", got.pad));
        endfunction

        function void close_out();
            if (owed.size() != 0)
                flag($sformatf("%0d results never arrived", owed.size()));
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [olst_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [olst_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    list_scoreboard sb;
    bit             hold_req;
    int             cycle_cnt;
    int             n_random;

    ordered_list_store dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    initial cycle_cnt = 0;
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // output side: random ready stretches, plus one long hold on request
    initial
    begin
        int mode;
        int stretch;
        m_axis_tready = 1'b0;
        mode = 0;
        stretch = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode = $urandom_range(0, 19);
                    stretch = (mode == 19) ? $urandom_range(20, 40)
                                           : $urandom_range(5, 60);
                end
                stretch--;
                if (mode < 7)
                    m_axis_tready <= 1'b1;
                else if (mode < 13)
                    m_axis_tready <= ($urandom_range(0, 9) < 7);
                else if (mode < 19)
                    m_axis_tready <= ($urandom_range(0, 9) < 3);
                else
                    m_axis_tready <= 1'b0;
            end
        end
    end

    // check every output transfer
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // offer one operation and hold it until the transfer
    task automatic send_op(input logic [olst_pkg::OP_W-1:0] op_code,
                           input logic [olst_pkg::VALUE_W-1:0] val,
                           input logic [olst_pkg::POS_W-1:0] pos);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pos, val, op_code};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_op(op_code, val, pos);
    endtask

    // random input gap: mostly none or short, now and then long
    task automatic idle_gap();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (r < 60)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else if (r < 98)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop offering until every owed result is back
    task automatic drain_pause();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // values: a small pool for duplicates, the extremes, or anything
    function automatic logic [olst_pkg::VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return olst_pkg::VALUE_W'($urandom_range(0, 7)) - 32'd3;
        else if (r < 60)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    // search keys hit a held entry about half the time
    function automatic logic [olst_pkg::VALUE_W-1:0] pick_key();
        if (sb.held != 0 && $urandom_range(0, 1) == 1)
            return sb.slots[$urandom_range(0, sb.held - 1)];
        return pick_value();
    endfunction

    function automatic logic [olst_pkg::POS_W-1:0] pick_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return olst_pkg::POS_W'($urandom_range(0, sb.held));
        else if (r < 80)
            return olst_pkg::POS_W'(sb.held);
        return olst_pkg::POS_W'($urandom_range(0, 31));
    endfunction

    // op mix leans on pushes when filling and on pops when draining
    function automatic logic [olst_pkg::OP_W-1:0] pick_op(phase_t kind);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 97)
            return ($urandom_range(0, 1) == 1) ? OP_NOP_7 : OP_NOP_6;
        case (kind)
            PH_FILL:
            begin
                if (r < 30) return olst_pkg::OP_PUSH_BACK;
                if (r < 55) return olst_pkg::OP_PUSH_FRONT;
                if (r < 78) return olst_pkg::OP_INSERT_AT;
                if (r < 90) return olst_pkg::OP_SEARCH;
                if (r < 94) return olst_pkg::OP_POP_FRONT;
                return olst_pkg::OP_POP_BACK;
            end
            PH_DRAIN:
            begin
                if (r < 32) return olst_pkg::OP_POP_FRONT;
                if (r < 64) return olst_pkg::OP_POP_BACK;
                if (r < 80) return olst_pkg::OP_SEARCH;
                if (r < 88) return olst_pkg::OP_INSERT_AT;
                return olst_pkg::OP_PUSH_BACK;
            end
            default:
            begin
                if (r < 16) return olst_pkg::OP_PUSH_FRONT;
                if (r < 32) return olst_pkg::OP_PUSH_BACK;
                if (r < 48) return olst_pkg::OP_POP_FRONT;
                if (r < 64) return olst_pkg::OP_POP_BACK;
                if (r < 80) return olst_pkg::OP_INSERT_AT;
                return olst_pkg::OP_SEARCH;
            end
        endcase
    endfunction

    // main sequence
    initial
    begin
        int          phase_no;
        int          len;
        bit          burst;
        phase_t      kind;
        logic [olst_pkg::OP_W-1:0] op_code;

        sb = new();
        hold_req = 1'b0;
        n_random = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty list corners
        send_op(olst_pkg::OP_POP_FRONT, 32'h0, 5'd0);
        send_op(olst_pkg::OP_POP_BACK, 32'hffff_ffff, 5'd31);
        send_op(olst_pkg::OP_SEARCH, 32'h0, 5'd0);
        send_op(olst_pkg::OP_INSERT_AT, 32'h1, 5'd1);
        send_op(olst_pkg::OP_INSERT_AT, 32'h7, 5'd0);
        send_op(olst_pkg::OP_INSERT_AT, 32'h9, 5'd31);
        idle_gap();
        // extremes, and a duplicate so the first match wins
        send_op(olst_pkg::OP_PUSH_FRONT, 32'h8000_0000, 5'd0);
        send_op(olst_pkg::OP_PUSH_BACK, 32'h7fff_ffff, 5'd0);
        send_op(olst_pkg::OP_PUSH_BACK, 32'h7, 5'd16);
        send_op(olst_pkg::OP_SEARCH, 32'h7, 5'd0);
        send_op(olst_pkg::OP_SEARCH, 32'h7fff_ffff, 5'd0);
        send_op(olst_pkg::OP_SEARCH, 32'h8000_0000, 5'd0);
        send_op(olst_pkg::OP_SEARCH, 32'd123, 5'd0);
        idle_gap();
        // insert at the count appends, insert in the middle
        send_op(olst_pkg::OP_INSERT_AT, 32'hffff_ffff, 5'd4);
        send_op(olst_pkg::OP_INSERT_AT, 32'h0, 5'd2);
        // unused op codes do nothing
        send_op(OP_NOP_6, 32'h1234_5678, 5'd3);
        send_op(OP_NOP_7, 32'hffff_ffff, 5'd31);
        send_op(olst_pkg::OP_PUSH_FRONT, 32'hffff_ffff, 5'd31);
        send_op(olst_pkg::OP_POP_FRONT, 32'h0, 5'd0);
        send_op(olst_pkg::OP_POP_BACK, 32'h0, 5'd0);
        send_op(olst_pkg::OP_SEARCH, 32'hffff_ffff, 5'd0);
        drain_pause();

        // random phases
        phase_no = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            phase_no++;
            kind  = phase_t'($urandom_range(0, 2));
            len   = $urandom_range(10, 50);
            burst = ($urandom_range(0, 3) == 0);
            if (phase_no == 4)
            begin
                // output held off while inputs keep coming
                hold_req = 1'b1;
                kind  = PH_FILL;
                len   = 40;
                burst = 1'b1;
            end
            if (phase_no == 7)
                drain_pause();
            repeat (len)
            begin
                op_code = pick_op(kind);
                if (op_code == olst_pkg::OP_SEARCH)
                    send_op(op_code, pick_key(), pick_pos());
                else
                    send_op(op_code, pick_value(), pick_pos());
                if (op_code <= olst_pkg::OP_SEARCH)
                    n_random++;
                if (!burst)
                    idle_gap();
            end
        end

        // let every result come back, then idle before the final check
        drain_pause();
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close_out();

        $display("%0d operations checked (%0d random), peak fill %0d of %0d",
                 sb.n_checked, n_random, sb.peak, LIST_DEPTH);
        $display("full %0d, empty %0d, out of bounds %0d, search hits %0d, mismatches %0d",
                 sb.n_full, sb.n_empty, sb.n_bounds, sb.n_found, sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
src/olst_pkg.sv
src/olst_cell.sv
src/ordered_list_store.sv
dv/tb_ordered_list_store.sv
